[src/bts_pkg.sv]
`default_nettype none

package bts_pkg;

    localparam int DEF_MAX_LEVELS   = 8;
    localparam int DEF_MAX_BUCKET   = 4;
    localparam int DEF_PAYLOAD_BITS = 64;

    localparam int KEY_W      = 32;
    localparam int CFG_LVL_W  = 4;
    localparam int CFG_CAP_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_USER_W = 3;

    localparam int LEVELS_RST = 8;
    localparam int CAP_RST    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP    = 1'd1;

    localparam int OSEL_W = 3;
    localparam logic [OSEL_W-1:0] OSEL_ERR    = 3'd0;
    localparam logic [OSEL_W-1:0] OSEL_PLACED = 3'd1;
    localparam logic [OSEL_W-1:0] OSEL_FULL   = 3'd2;
    localparam logic [OSEL_W-1:0] OSEL_MID    = 3'd3;
    localparam logic [OSEL_W-1:0] OSEL_END    = 3'd4;

    typedef struct packed {
        logic              cap_item;
        logic              init_walk;
        logic              step;
        logic              latch_fill;
        logic              do_place;
        logic              j_inc;
        logic              pend_load;
        logic              out_load;
        logic [OSEL_W-1:0] out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic leaf_bad;
        logic is_read;
        logic fits;
        logic fill_zero;
        logic at_end;
        logic slot_last;
        logic pend_valid;
        logic out_free;
    } t_dp_sts;

    function automatic int leaf_w(int max_levels);
        return (max_levels > 1) ? max_levels - 1 : 1;
    endfunction

    function automatic int slot_w(int max_bucket);
        return (max_bucket > 1) ? $clog2(max_bucket) : 1;
    endfunction

    function automatic int fill_w(int max_bucket);
        return $clog2(max_bucket + 1);
    endfunction

    function automatic int in_tdata_w(int max_levels, int payload_bits);
        int w;
        w = leaf_w(max_levels) + KEY_W + payload_bits;
        return ((w + 7) >> 3) << 3;
    endfunction

    function automatic int out_tdata_w(int max_levels, int max_bucket, int payload_bits);
        int w;
        w = max_levels + slot_w(max_bucket) + KEY_W + leaf_w(max_levels) + payload_bits;
        return ((w + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

[src/bts_ctrl.sv]
`default_nettype none

module bts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  bts_pkg::t_dp_sts i_sts,
    output bts_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_FILL_RD  = 3'd2;
    localparam logic [2:0] ST_FILL_CHK = 3'd3;
    localparam logic [2:0] ST_SLOT_RD  = 3'd4;
    localparam logic [2:0] ST_SLOT_CHK = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.cap_item = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.leaf_bad) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = bts_pkg::OSEL_ERR;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.init_walk = 1'b1;
                    n_state         = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                n_state = ST_FILL_CHK;
            end
            ST_FILL_CHK: begin
                if (!i_sts.is_read) begin
                    if (i_sts.fits) begin
                        if (i_sts.out_free) begin
                            o_cmd.do_place = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = bts_pkg::OSEL_PLACED;
                            n_state        = ST_IDLE;
                        end
                    end else if (i_sts.at_end) begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = bts_pkg::OSEL_FULL;
                            n_state        = ST_IDLE;
                        end
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_FILL_RD;
                    end
                end else begin
                    o_cmd.latch_fill = 1'b1;
                    if (!i_sts.fill_zero) begin
                        n_state = ST_SLOT_RD;
                    end else if (i_sts.at_end) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_FILL_RD;
                    end
                end
            end
            ST_SLOT_RD: begin
                n_state = ST_SLOT_CHK;
            end
            ST_SLOT_CHK: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    if (i_sts.pend_valid) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = bts_pkg::OSEL_MID;
                    end
                    o_cmd.pend_load = 1'b1;
                    if (!i_sts.slot_last) begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = ST_SLOT_RD;
                    end else if (i_sts.at_end) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_FILL_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = bts_pkg::OSEL_END;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a beat not yet taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_place |-> (i_sts.fits && !i_sts.is_read))
        else $error("block stored into a full bucket or on a read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap_item |=> (r_state == ST_CHECK))
        else $error("accepted item not checked next cycle");

endmodule

`default_nettype wire

[src/bts_dpath.sv]
`default_nettype none

module bts_dpath #(
    parameter int MAX_LEVELS   = bts_pkg::DEF_MAX_LEVELS,
    parameter int MAX_BUCKET   = bts_pkg::DEF_MAX_BUCKET,
    parameter int PAYLOAD_BITS = bts_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]                          i_cfg_idx,
    input  logic [bts_pkg::CFG_DATA_W-1:0]                         i_cfg_data,
    input  logic [bts_pkg::in_tdata_w(MAX_LEVELS, PAYLOAD_BITS)-1:0] i_s_axis_tdata,
    input  logic                                                   i_s_axis_tuser,
    input  logic                                                   i_m_axis_tready,
    output logic                                                   o_m_axis_tvalid,
    output logic [bts_pkg::out_tdata_w(MAX_LEVELS, MAX_BUCKET, PAYLOAD_BITS)-1:0]
                                                                   o_m_axis_tdata,
    output logic [bts_pkg::OUT_USER_W-1:0]                         o_m_axis_tuser,
    output logic                                                   o_m_axis_tlast,
    input  bts_pkg::t_dp_cmd                                       i_cmd,
    output bts_pkg::t_dp_sts                                       o_sts
);

    localparam int NODE_W     = MAX_LEVELS;
    localparam int LEAF_W     = bts_pkg::leaf_w(MAX_LEVELS);
    localparam int SLOT_W     = bts_pkg::slot_w(MAX_BUCKET);
    localparam int FILL_W     = bts_pkg::fill_w(MAX_BUCKET);
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int KEY_W      = bts_pkg::KEY_W;
    localparam int NODE_CNT   = (1 << MAX_LEVELS) - 1;
    localparam int SLOT_CNT   = NODE_CNT << SLOT_W;
    localparam int SLOT_DW    = KEY_W + LEAF_W + PAYLOAD_BITS;
    localparam int OUT_TDATA_W = bts_pkg::out_tdata_w(MAX_LEVELS, MAX_BUCKET, PAYLOAD_BITS);
    localparam int LVL_RST_I  = (bts_pkg::LEVELS_RST > MAX_LEVELS) ? MAX_LEVELS
                                                                 : bts_pkg::LEVELS_RST;
    localparam int CAP_RST_I  = (bts_pkg::CAP_RST > MAX_BUCKET) ? MAX_BUCKET
                                                              : bts_pkg::CAP_RST;

    logic [LVL_W-1:0]  r_levels, n_levels;
    logic [FILL_W-1:0] r_cap, n_cap;
    logic [bts_pkg::CFG_LVL_W-1:0] cfg_lvl;
    logic [bts_pkg::CFG_CAP_W-1:0] cfg_cap;

    logic                    r_kind;
    logic [LEAF_W-1:0]       r_leaf;
    logic [KEY_W-1:0]        r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;

    logic [NODE_W-1:0] r_pos;
    logic [LVL_W-1:0]  r_sh;
    logic [NODE_W-1:0] base;
    logic [NODE_W-1:0] node;
    logic [LVL_W-1:0]  lvl_m1;

    logic [FILL_W-1:0] r_fill_mem [NODE_CNT];
    logic [FILL_W-1:0] r_fill_q;
    logic [NODE_CNT-1:0] r_fvld;
    logic              r_fvld_q;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] r_nfill;
    logic [FILL_W-1:0] r_j;

    logic [SLOT_DW-1:0] r_slot_mem [SLOT_CNT];
    logic [SLOT_DW-1:0] r_slot_q;
    logic [SLOT_W-1:0]  slot_sel;
    logic [NODE_W+SLOT_W-1:0] slot_addr;

    logic                    r_pend_valid;
    logic [NODE_W-1:0]       r_pend_node;
    logic [SLOT_W-1:0]       r_pend_slot;
    logic [KEY_W-1:0]        r_pend_key;
    logic [LEAF_W-1:0]       r_pend_leaf;
    logic [PAYLOAD_BITS-1:0] r_pend_pay;

    logic                    r_out_valid;
    logic                    r_out_bvalid, n_out_bvalid;
    logic                    r_out_placed, n_out_placed;
    logic                    r_out_err, n_out_err;
    logic [NODE_W-1:0]       r_out_node, n_out_node;
    logic [SLOT_W-1:0]       r_out_slot, n_out_slot;
    logic [KEY_W-1:0]        r_out_key, n_out_key;
    logic [LEAF_W-1:0]       r_out_leaf, n_out_leaf;
    logic [PAYLOAD_BITS-1:0] r_out_pay, n_out_pay;
    logic                    r_out_last, n_out_last;

    assign cfg_lvl = i_cfg_data[bts_pkg::CFG_LVL_W-1:0];
    assign cfg_cap = i_cfg_data[bts_pkg::CFG_CAP_W-1:0];

    always_comb begin
        n_levels = r_levels;
        n_cap    = r_cap;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bts_pkg::REG_LEVELS: begin
                    if (cfg_lvl == '0) begin
                        n_levels = LVL_W'(1);
                    end else if (int'(cfg_lvl) > MAX_LEVELS) begin
                        n_levels = LVL_W'(MAX_LEVELS);
                    end else begin
                        n_levels = LVL_W'(cfg_lvl);
                    end
                end
                bts_pkg::REG_CAP: begin
                    if (cfg_cap == '0) begin
                        n_cap = FILL_W'(1);
                    end else if (int'(cfg_cap) > MAX_BUCKET) begin
                        n_cap = FILL_W'(MAX_BUCKET);
                    end else begin
                        n_cap = FILL_W'(cfg_cap);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LVL_W'(LVL_RST_I);
            r_cap    <= FILL_W'(CAP_RST_I);
        end else begin
            r_levels <= n_levels;
            r_cap    <= n_cap;
        end
    end

    assign lvl_m1 = r_levels - 1'b1;
    assign base   = (NODE_W'(1) << lvl_m1) | NODE_W'(r_leaf);
    assign node   = r_pos - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_kind <= i_s_axis_tuser;
            r_leaf <= i_s_axis_tdata[LEAF_W-1:0];
            r_key  <= i_s_axis_tdata[LEAF_W +: KEY_W];
            r_pay  <= i_s_axis_tdata[LEAF_W + KEY_W +: PAYLOAD_BITS];
        end
        if (i_cmd.init_walk) begin
            r_pos <= r_kind ? NODE_W'(1) : base;
            r_sh  <= lvl_m1;
        end else if (i_cmd.step) begin
            if (r_kind) begin
                r_pos <= base >> (r_sh - 1'b1);
                r_sh  <= r_sh - 1'b1;
            end else begin
                r_pos <= r_pos >> 1;
            end
        end
        if (i_cmd.latch_fill) begin
            r_nfill <= fill_eff;
            r_j     <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + 1'b1;
        end
    end

    // bucket fill counts: valid bits stand in for clearing the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_fvld <= '0;
        end else if (i_cmd.do_place) begin
            r_fvld[node] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_place) begin
            r_fill_mem[node] <= fill_eff + 1'b1;
        end
        r_fill_q <= r_fill_mem[node];
        r_fvld_q <= r_fvld[node];
    end

    assign fill_eff = r_fvld_q ? r_fill_q : '0;

    assign slot_sel  = i_cmd.do_place ? fill_eff[SLOT_W-1:0] : r_j[SLOT_W-1:0];
    assign slot_addr = {node, slot_sel};

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_place) begin
            r_slot_mem[slot_addr] <= {r_pay, r_leaf, r_key};
        end
        r_slot_q <= r_slot_mem[slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.init_walk) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_load) begin
            r_pend_valid <= 1'b1;
        end
        if (i_cmd.pend_load) begin
            r_pend_node <= node;
            r_pend_slot <= r_j[SLOT_W-1:0];
            r_pend_key  <= r_slot_q[KEY_W-1:0];
            r_pend_leaf <= r_slot_q[KEY_W +: LEAF_W];
            r_pend_pay  <= r_slot_q[KEY_W + LEAF_W +: PAYLOAD_BITS];
        end
    end

    always_comb begin
        n_out_bvalid = 1'b0;
        n_out_placed = 1'b0;
        n_out_err    = 1'b0;
        n_out_node   = '0;
        n_out_slot   = '0;
        n_out_key    = '0;
        n_out_leaf   = '0;
        n_out_pay    = '0;
        n_out_last   = 1'b1;
        unique case (i_cmd.out_sel) inside
            bts_pkg::OSEL_ERR: begin
                n_out_err = 1'b1;
            end
            bts_pkg::OSEL_PLACED: begin
                n_out_placed = 1'b1;
                n_out_node   = node;
                n_out_slot   = fill_eff[SLOT_W-1:0];
            end
            bts_pkg::OSEL_FULL: ;
            bts_pkg::OSEL_MID, bts_pkg::OSEL_END: begin
                if (r_pend_valid) begin
                    n_out_bvalid = 1'b1;
                    n_out_node   = r_pend_node;
                    n_out_slot   = r_pend_slot;
                    n_out_key    = r_pend_key;
                    n_out_leaf   = r_pend_leaf;
                    n_out_pay    = r_pend_pay;
                end
                n_out_last = (i_cmd.out_sel == bts_pkg::OSEL_END);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_bvalid <= n_out_bvalid;
            r_out_placed <= n_out_placed;
            r_out_err    <= n_out_err;
            r_out_node   <= n_out_node;
            r_out_slot   <= n_out_slot;
            r_out_key    <= n_out_key;
            r_out_leaf   <= n_out_leaf;
            r_out_pay    <= n_out_pay;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_pay, r_out_leaf, r_out_key,
                                           r_out_slot, r_out_node});
    assign o_m_axis_tuser  = {r_out_err, r_out_placed, r_out_bvalid};
    assign o_m_axis_tlast  = r_out_last;

    assign o_sts.leaf_bad   = ((NODE_W'(r_leaf) >> lvl_m1) != '0);
    assign o_sts.is_read    = r_kind;
    assign o_sts.fits       = (fill_eff < r_cap);
    assign o_sts.fill_zero  = (fill_eff == '0);
    assign o_sts.at_end     = r_kind ? (r_sh == '0) : (r_pos == NODE_W'(1));
    assign o_sts.slot_last  = (FILL_W'(r_j + 1'b1) == r_nfill);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = !r_out_valid || i_m_axis_tready;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_fvld == '0))
        else $error("tree not cleared after register write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_out_bvalid)
        else $error("non-final beat carries no block");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_placed || r_out_err)) |-> (!r_out_bvalid && r_out_last))
        else $error("place or error beat malformed");

endmodule

`default_nettype wire

[src/bucket_tree_path_store.sv]
`default_nettype none

// Channel   Dir  Beat                            Fields (low bit up)
// s_axis    in   tvalid & tready                 tdata: leaf_id, block_key, block_payload
//                                                tuser: kind
// m_axis    out  tvalid & tready                 tdata: node_index, slot_index, out_key,
//                                                       out_leaf, out_payload
//                                                tuser: block_valid, placed, error; tlast: last
// cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
// One item at a time. Place: capture and leaf check, then a fill read and fill check
// per bucket visited going up. Read: the same start, then a fill read and check per
// bucket on the path going down, a slot read and check per stored block, and a finish
// state to close. The bucket fill memory and slot memory have one registered read each.
// Reset and any register write empty the tree at once through per-bucket valid bits.
// A result stall holds the walk while one finished result and one pending block wait.

module bucket_tree_path_store #(
    parameter int MAX_LEVELS   = bts_pkg::DEF_MAX_LEVELS,
    parameter int MAX_BUCKET   = bts_pkg::DEF_MAX_BUCKET,
    parameter int PAYLOAD_BITS = bts_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]                          i_cfg_idx,
    input  logic [bts_pkg::CFG_DATA_W-1:0]                         i_cfg_data,
    input  logic                                                   i_s_axis_tvalid,
    output logic                                                   o_s_axis_tready,
    // leaf_id, block_key, block_payload
    input  logic [bts_pkg::in_tdata_w(MAX_LEVELS, PAYLOAD_BITS)-1:0] i_s_axis_tdata,
    // kind
    input  logic                                                   i_s_axis_tuser,
    output logic                                                   o_m_axis_tvalid,
    input  logic                                                   i_m_axis_tready,
    // node_index, slot_index, out_key, out_leaf, out_payload
    output logic [bts_pkg::out_tdata_w(MAX_LEVELS, MAX_BUCKET, PAYLOAD_BITS)-1:0]
                                                                   o_m_axis_tdata,
    // block_valid, placed, error
    output logic [bts_pkg::OUT_USER_W-1:0]                         o_m_axis_tuser,
    output logic                                                   o_m_axis_tlast
);

    bts_pkg::t_dp_cmd cmd;
    bts_pkg::t_dp_sts sts;

    bts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    bts_dpath #(
        .MAX_LEVELS   (MAX_LEVELS),
        .MAX_BUCKET   (MAX_BUCKET),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

`default_nettype wire

[tb/tb_bts_pkg.sv]
`timescale 1ns / 1ps

package tb_bts_pkg;

    localparam int IN_W  = bts_pkg::in_tdata_w(bts_pkg::DEF_MAX_LEVELS,
                                               bts_pkg::DEF_PAYLOAD_BITS);
    localparam int OUT_W = bts_pkg::out_tdata_w(bts_pkg::DEF_MAX_LEVELS,
                                                bts_pkg::DEF_MAX_BUCKET,
                                                bts_pkg::DEF_PAYLOAD_BITS);

    typedef enum logic {
        KIND_PLACE = 1'b0,
        KIND_READ  = 1'b1
    } t_item_kind;

endpackage

[tb/bts_path_checker.sv]
`timescale 1ns / 1ps

module bts_path_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bts_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_s_tvalid,
    input  logic                                  i_s_tready,
    // leaf_id, block_key, block_payload
    input  logic [tb_bts_pkg::IN_W-1:0]           i_s_tdata,
    // kind
    input  logic                                  i_s_tuser,
    input  logic                                  i_m_tvalid,
    input  logic                                  i_m_tready,
    // node_index, slot_index, out_key, out_leaf, out_payload
    input  logic [tb_bts_pkg::OUT_W-1:0]          i_m_tdata,
    // block_valid, placed, error
    input  logic [bts_pkg::OUT_USER_W-1:0]        i_m_tuser,
    input  logic                                  i_m_tlast,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    localparam int NODES  = (1 << bts_pkg::DEF_MAX_LEVELS) - 1;
    localparam int STRIDE = bts_pkg::DEF_MAX_BUCKET;
    localparam int LVL_W  = bts_pkg::CFG_LVL_W;
    localparam int CAP_W  = bts_pkg::CFG_CAP_W;

    typedef struct packed {
        logic        blk_valid;
        logic        placed;
        logic        err;
        logic [7:0]  node;
        logic [1:0]  slot;
        logic [31:0] key;
        logic [6:0]  leaf;
        logic [63:0] payload;
        logic        last;
    } t_path_entry;

    logic [2:0]  bucket_fill [0:NODES-1];
    logic [31:0] stored_key  [0:NODES*STRIDE-1];
    logic [6:0]  stored_leaf [0:NODES*STRIDE-1];
    logic [63:0] stored_pay  [0:NODES*STRIDE-1];
    logic [LVL_W-1:0] levels_reg;
    logic [CAP_W-1:0] cap_reg;
    t_path_entry path_results_q [$];
    int fail_total;

    function automatic void empty_tree();
        for (int n = 0; n < NODES; n++)
            bucket_fill[n] = '0;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void predict_item(logic kind, logic [6:0] leaf, logic [31:0] key,
                                         logic [63:0] pay);
        int unsigned lv, cap, span, d, j, node, total, k;
        int unsigned path_nodes [bts_pkg::DEF_MAX_LEVELS];
        logic done;
        t_path_entry r;
        lv   = (levels_reg == 0) ? 1 :
               (levels_reg > bts_pkg::DEF_MAX_LEVELS) ? bts_pkg::DEF_MAX_LEVELS : levels_reg;
        cap  = (cap_reg == 0) ? 1 :
               (cap_reg > bts_pkg::DEF_MAX_BUCKET) ? bts_pkg::DEF_MAX_BUCKET : cap_reg;
        span = 1 << (lv - 1);
        r = '0;
        r.last = 1'b1;
        if (leaf >= span) begin
            r.err = 1'b1;
            path_results_q = {path_results_q, r};
        end else begin
            path_nodes[lv-1] = span - 1 + leaf;
            for (d = lv - 1; d > 0; d--)
                path_nodes[d-1] = (path_nodes[d] - 1) >> 1;
            if (kind == tb_bts_pkg::KIND_PLACE) begin
                done = 1'b0;
                for (d = lv; d > 0 && !done; d--) begin
                    node = path_nodes[d-1];
                    if (bucket_fill[node] < cap) begin
                        k = node * STRIDE + bucket_fill[node];
                        stored_key[k]  = key;
                        stored_leaf[k] = leaf;
                        stored_pay[k]  = pay;
                        r.placed = 1'b1;
                        r.node   = 8'(node);
                        r.slot   = 2'(bucket_fill[node]);
                        bucket_fill[node] = bucket_fill[node] + 3'd1;
                        done = 1'b1;
                    end
                end
                path_results_q = {path_results_q, r};
            end else begin
                total = 0;
                for (d = 0; d < lv; d++)
                    total += bucket_fill[path_nodes[d]];
                if (total == 0) begin
                    path_results_q = {path_results_q, r};
                end else begin
                    k = 0;
                    for (d = 0; d < lv; d++) begin
                        node = path_nodes[d];
                        for (j = 0; j < bucket_fill[node]; j++) begin
                            r = '0;
                            r.blk_valid = 1'b1;
                            r.node      = 8'(node);
                            r.slot      = 2'(j);
                            r.key       = stored_key[node*STRIDE+j];
                            r.leaf      = stored_leaf[node*STRIDE+j];
                            r.payload   = stored_pay[node*STRIDE+j];
                            r.last      = (k == total - 1);
                            path_results_q = {path_results_q, r};
                            k++;
                        end
                    end
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_path_entry got, want;
        if (!i_rst_n) begin
            levels_reg = LVL_W'(bts_pkg::LEVELS_RST);
            cap_reg    = CAP_W'(bts_pkg::CAP_RST);
            empty_tree();
            path_results_q.delete();
            fail_total = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '0;
                got.blk_valid = i_m_tuser[0];
                got.placed    = i_m_tuser[1];
                got.err       = i_m_tuser[2];
                got.node      = i_m_tdata[7:0];
                got.slot      = i_m_tdata[9:8];
                got.key       = i_m_tdata[41:10];
                got.leaf      = i_m_tdata[48:42];
                got.payload   = i_m_tdata[112:49];
                got.last      = i_m_tlast;
                if (path_results_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: result beat expected none actual %h", $time, got);
                end else begin
                    want = path_results_q.pop_front();
                    check_field("block_valid", 64'(want.blk_valid), 64'(got.blk_valid));
                    check_field("placed", 64'(want.placed), 64'(got.placed));
                    check_field("error", 64'(want.err), 64'(got.err));
                    check_field("node_index", 64'(want.node), 64'(got.node));
                    check_field("slot_index", 64'(want.slot), 64'(got.slot));
                    check_field("out_key", 64'(want.key), 64'(got.key));
                    check_field("out_leaf", 64'(want.leaf), 64'(got.leaf));
                    check_field("out_payload", want.payload, got.payload);
                    check_field("last", 64'(want.last), 64'(got.last));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == bts_pkg::REG_LEVELS)
                    levels_reg = i_cfg_data[bts_pkg::CFG_LVL_W-1:0];
                else
                    cap_reg = i_cfg_data[bts_pkg::CFG_CAP_W-1:0];
                empty_tree();
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(i_s_tuser, i_s_tdata[6:0], i_s_tdata[38:7], i_s_tdata[102:39]);
        end
        o_fail_count <= fail_total;
        o_pending    <= path_results_q.size();
    end

endmodule

[tb/tb_bucket_tree_path_store.sv]
`timescale 1ns / 1ps

module tb_bucket_tree_path_store;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CFG_HOLDOFF    = 20;
    localparam int END_SETTLE     = 100;
    localparam int N_PHASES       = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_COMB,
        STALL_SPARSE
    } t_stall;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [bts_pkg::CFG_IDX_W-1:0]         i_cfg_idx = '0;
    logic [bts_pkg::CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                                  i_s_axis_tvalid = 1'b0;
    logic                                  o_s_axis_tready;
    logic [tb_bts_pkg::IN_W-1:0]           i_s_axis_tdata = '0;
    logic                                  i_s_axis_tuser = 1'b0;
    logic                                  o_m_axis_tvalid;
    logic                                  i_m_axis_tready = 1'b0;
    logic [tb_bts_pkg::OUT_W-1:0]          o_m_axis_tdata;
    logic [bts_pkg::OUT_USER_W-1:0]        o_m_axis_tuser;
    logic                                  o_m_axis_tlast;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int tree_span = 128;
    t_stall stall_mode = STALL_NONE;
    int mode_left = 0;
    int comb_phase = 0;

    always #6 i_clk = ~i_clk;

    bucket_tree_path_store u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    bts_path_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_m_tlast    (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            mode_left  <= $urandom_range(40, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        comb_phase <= (comb_phase == 6) ? 0 : comb_phase + 1;
        case (stall_mode)
            STALL_NONE:   i_m_axis_tready <= 1'b1;
            STALL_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_COMB:   i_m_axis_tready <= (comb_phase < 3);
            STALL_SPARSE: i_m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(tb_bts_pkg::t_item_kind kind, logic [6:0] leaf,
                             logic [31:0] key, logic [63:0] pay);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!steady)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, pay, key, leaf};
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx,
                             logic [bts_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (CFG_HOLDOFF) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_tree(logic [3:0] lv, logic [3:0] cap);
        int eff;
        eff = (lv == 0) ? 1 : (lv > bts_pkg::DEF_MAX_LEVELS) ? bts_pkg::DEF_MAX_LEVELS : lv;
        write_reg(bts_pkg::REG_LEVELS, lv);
        write_reg(bts_pkg::REG_CAP, cap);
        tree_span = 1 << (eff - 1);
    endtask

    initial begin : stimulus
        logic [3:0] phase_lv  [N_PHASES];
        logic [3:0] phase_cap [N_PHASES];
        int lv_eff, cap_eff, n_fill, hot, roll;
        logic [6:0] leaf;
        tb_bts_pkg::t_item_kind kind;

        phase_lv  = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd2, 4'd8};
        phase_cap = '{4'd4, 4'd2, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd12};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: eight levels, four slots
        steady = 1'b1;
        send_item(tb_bts_pkg::KIND_READ,  7'd0,   32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd0,   32'h8000_0000, 64'h0);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd127, 32'h7fff_ffff, {64{1'b1}});
        send_item(tb_bts_pkg::KIND_PLACE, 7'd127, 32'hffff_ffff, 64'h1);
        send_item(tb_bts_pkg::KIND_READ,  7'd127, 32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd0,   32'h0,         64'h0);

        // two levels, one slot: fill a path, overflow it, leaves out of range
        set_tree(4'd2, 4'd1);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd1,   32'h1234_5678, 64'hdead_beef_0bad_f00d);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd1,   32'h0000_0001, 64'h8000_0000_0000_0000);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd1,   32'h0000_0002, 64'h5555_aaaa_5555_aaaa);
        send_item(tb_bts_pkg::KIND_READ,  7'd1,   32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd0,   32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd2,   32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd127, 32'h0,         64'h0);

        // zero in both registers saturates up to one level, one slot
        set_tree(4'd0, 4'd0);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd0,   32'hffff_fffe, 64'h0123_4567_89ab_cdef);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd0,   32'h0000_0003, 64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd0,   32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd1,   32'h0,         64'h0);

        // oversized values saturate down
        set_tree(4'd15, 4'd15);
        send_item(tb_bts_pkg::KIND_READ,  7'd127, 32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_PLACE, 7'd64,  32'h0,         64'h0);
        send_item(tb_bts_pkg::KIND_READ,  7'd64,  32'h0,         64'h0);

        for (int p = 0; p < N_PHASES; p++) begin
            set_tree(phase_lv[p], phase_cap[p]);
            steady  = (p % 3 == 0);
            lv_eff  = (phase_lv[p] == 0) ? 1 : (phase_lv[p] > 8) ? 8 : phase_lv[p];
            cap_eff = phase_cap[p][2:0];
            cap_eff = (cap_eff == 0) ? 1 : (cap_eff > 4) ? 4 : cap_eff;
            n_fill  = lv_eff * cap_eff + 2;
            hot     = $urandom_range(0, tree_span - 1);
            // fill one path to the top and over
            for (int i = 0; i < n_fill; i++)
                send_item(tb_bts_pkg::KIND_PLACE, 7'(hot), $urandom, {$urandom, $urandom});
            for (int i = 0; i < 30; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 10 && tree_span < 128)
                    leaf = 7'($urandom_range(tree_span, 127));
                else if (roll < 55)
                    leaf = 7'(hot);
                else
                    leaf = 7'($urandom_range(0, tree_span - 1));
                kind = ($urandom_range(0, 9) < 4) ? tb_bts_pkg::KIND_READ
                                                  : tb_bts_pkg::KIND_PLACE;
                send_item(kind, leaf, $urandom, {$urandom, $urandom});
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
